// ----- hdl/monotone_chain_convex_hull_macros.svh -----
// assertion helpers shared by the hull block
// each macro expects clk and arst_n in scope
`ifndef MONOTONE_CHAIN_CONVEX_HULL_MACROS_SVH
`define MONOTONE_CHAIN_CONVEX_HULL_MACROS_SVH

// condition that holds at every edge outside reset
`define MCCH_CHECK(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// condition in the cycle after a trigger
`define MCCH_CHECK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/mcch_pkg.sv -----
package mcch_pkg;

	// hull sequencer states
	typedef enum logic [3:0] {
		ST_LOAD,
		ST_INIT_A,
		ST_INIT_B,
		ST_INIT_C,
		ST_FETCH,
		ST_FETCH_W,
		ST_TEST,
		ST_WAIT,
		ST_RLD_S,
		ST_RLD_P,
		ST_RLD_W,
		ST_PUSH,
		ST_E_STK,
		ST_E_PT,
		ST_E_LD,
		ST_E_WAIT
	} hull_state_t;

	// orientation unit phases
	typedef enum logic [1:0] {
		OP_IDLE,
		OP_MUL1,
		OP_MUL2,
		OP_CMP
	} orient_phase_t;

	// orientation unit result
	typedef struct packed {
		logic done;
		logic pop;
	} orient_res_t;

endpackage

// ----- hdl/mcch_ram.sv -----
module mcch_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- hdl/mcch_orient.sv -----
module mcch_orient #(
	parameter int COORD_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic signed [COORD_BITS-1:0] cx,
	input  logic signed [COORD_BITS-1:0] cy,
	input  logic signed [COORD_BITS-1:0] ax,
	input  logic signed [COORD_BITS-1:0] ay,
	input  logic signed [COORD_BITS-1:0] bx,
	input  logic signed [COORD_BITS-1:0] by,
	output mcch_pkg::orient_res_t        res
);
	import mcch_pkg::*;

	localparam int DW1 = COORD_BITS + 1;
	localparam int PW  = 2 * DW1;
	localparam int MSB = COORD_BITS - 1;

	orient_phase_t phase_q, phase_d;

	logic signed [DW1-1:0] dax_q, day_q, dbx_q, dby_q;
	logic signed [DW1-1:0] dax_d, day_d, dbx_d, dby_d;
	logic signed [DW1-1:0] op_a, op_b;
	logic signed [PW-1:0]  prod_d, prod_q, p1_q;

	// differences against the current point, exact in one extra bit
	assign dax_d = {ax[MSB], ax} - {cx[MSB], cx};
	assign day_d = {ay[MSB], ay} - {cy[MSB], cy};
	assign dbx_d = {bx[MSB], bx} - {cx[MSB], cx};
	assign dby_d = {by[MSB], by} - {cy[MSB], cy};

	// single shared multiplier, two products in turn
	assign op_a   = (phase_q == OP_MUL1) ? dax_q : day_q;
	assign op_b   = (phase_q == OP_MUL1) ? dby_q : dbx_q;
	assign prod_d = PW'(op_a) * PW'(op_b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= OP_IDLE;
		end else begin
			phase_q <= phase_d;
		end
	end

	// phase sequence and result
	always_comb begin
		phase_d  = phase_q;
		res.done = 1'b0;
		res.pop  = 1'b0;
		unique case (phase_q)
			OP_IDLE: begin
				if (start) phase_d = OP_MUL1;
			end
			OP_MUL1: phase_d = OP_MUL2;
			OP_MUL2: phase_d = OP_CMP;
			OP_CMP: begin
				res.done = 1'b1;
				res.pop  = (p1_q >= prod_q);
				phase_d  = OP_IDLE;
			end
			default: phase_d = OP_IDLE;
		endcase
	end

	// operand and product registers
	always_ff @(posedge clk) begin
		if (phase_q == OP_IDLE && start) begin
			dax_q <= dax_d;
			day_q <= day_d;
			dbx_q <= dbx_d;
			dby_q <= dby_d;
		end
		if (phase_q == OP_MUL1) begin
			prod_q <= prod_d;
		end
		if (phase_q == OP_MUL2) begin
			p1_q   <= prod_q;
			prod_q <= prod_d;
		end
	end

endmodule

// ----- hdl/monotone_chain_convex_hull.sv -----
// Convex hull of an x-sorted point set by the monotone chain method. Points
// arrive one per beat on the slave side and are taken at one per cycle; the
// beat with tlast set closes the set and starts the hull, and s_tready stays
// low until the last hull vertex has been taken on the master side. Points
// beyond MAX_POINTS are dropped and every vertex of that hull carries the
// overflow flag in m_tuser. Sets of one or two points come back unchanged.
// After loading, each pass sets up its first two stack entries, then fetches
// and tests each point in turn; a pop that leaves at least two entries reloads
// the new next-to-top through the stack and point memories, which have
// registered read ports, and every orientation test runs through one shared
// multiplier. Each vertex is then read out through the stack and point
// memories (the point memory alone for sets of one or two points) and held
// until the master side takes it.
`include "monotone_chain_convex_hull_macros.svh"

module monotone_chain_convex_hull #(
	parameter int MAX_POINTS = 64,
	parameter int COORD_BITS = 16,
	localparam int DW = ((2 * COORD_BITS + 7) / 8) * 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [DW-1:0] s_tdata,   // px, py
	input  logic          s_tlast,   // final_point
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [DW-1:0] m_tdata,   // hx, hy
	output logic          m_tlast,   // end_of_hull
	output logic          m_tuser    // overflowed
);
	import mcch_pkg::*;

	localparam int CB = COORD_BITS;
	localparam int IW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int PT = 2 * CB;

	hull_state_t state_q, state_d;

	// control registers
	logic [CW-1:0] cnt_q, n_q, left_q, dep_q, fdep_q;
	logic          drop_q, sel_q, small_q, m_valid_q;
	logic [IW-1:0] c_q, e_idx_q;

	// payload registers
	logic signed [CB-1:0] ax_q, ay_q, bx_q, by_q, cx_q, cy_q, hx_q, hy_q;
	logic                 m_last_q, m_ovf_q;

	// memory ports
	logic          pt_we;
	logic [IW-1:0] pt_raddr;
	logic [PT-1:0] pt_wdata, pt_rd;
	logic          stk_we, fs_we, bs_we;
	logic [IW-1:0] stk_waddr, stk_wdata, stk_raddr, fs_rd, bs_rd, stk_rd;

	logic        o_start;
	orient_res_t ores;

	// derived values
	logic          in_acc, full, stk_full;
	logic [CW-1:0] cnt_nxt, n_m1, n_m2, n_m3, dep_push, dep_m2, fdep_m2, emit_tot;
	logic [CW:0]   tot_sum;
	logic [IW-1:0] first_idx, second_idx;
	logic signed [CB-1:0] rd_x, rd_y;

	assign in_acc   = s_tvalid && s_tready;
	assign full     = (cnt_q == CW'(MAX_POINTS));
	assign cnt_nxt  = full ? cnt_q : cnt_q + CW'(1);
	assign n_m1     = n_q - CW'(1);
	assign n_m2     = n_q - CW'(2);
	assign n_m3     = n_q - CW'(3);
	assign stk_full = (dep_q == CW'(MAX_POINTS));
	assign dep_push = stk_full ? dep_q : dep_q + CW'(1);
	assign dep_m2   = dep_q - CW'(2);
	assign fdep_m2  = fdep_q - CW'(2);
	assign tot_sum  = {1'b0, dep_push} + {1'b0, fdep_q} - (CW+1)'(2);
	assign emit_tot = (tot_sum > (CW+1)'(MAX_POINTS)) ? CW'(MAX_POINTS) : tot_sum[CW-1:0];

	// pass end points: forward starts at 0,1 and backward at n-1,n-2
	assign first_idx  = sel_q ? n_m1[IW-1:0] : '0;
	assign second_idx = sel_q ? n_m2[IW-1:0] : IW'(1);

	assign pt_wdata = {s_tdata[PT-1:CB], s_tdata[CB-1:0]};
	assign rd_x     = pt_rd[CB-1:0];
	assign rd_y     = pt_rd[PT-1:CB];
	assign fs_we    = stk_we && !sel_q;
	assign bs_we    = stk_we && sel_q;
	assign stk_rd   = sel_q ? bs_rd : fs_rd;

	mcch_ram #(.WIDTH(PT), .DEPTH(MAX_POINTS)) u_points (
		.clk   (clk),
		.we    (pt_we),
		.waddr (cnt_q[IW-1:0]),
		.wdata (pt_wdata),
		.raddr (pt_raddr),
		.rdata (pt_rd)
	);

	mcch_ram #(.WIDTH(IW), .DEPTH(MAX_POINTS)) u_fwd_stack (
		.clk   (clk),
		.we    (fs_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.raddr (stk_raddr),
		.rdata (fs_rd)
	);

	mcch_ram #(.WIDTH(IW), .DEPTH(MAX_POINTS)) u_bwd_stack (
		.clk   (clk),
		.we    (bs_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.raddr (stk_raddr),
		.rdata (bs_rd)
	);

	// a = next-to-top, b = top, c = current point
	mcch_orient #(.COORD_BITS(CB)) u_orient (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (o_start),
		.cx     (cx_q),
		.cy     (cy_q),
		.ax     (ax_q),
		.ay     (ay_q),
		.bx     (bx_q),
		.by     (by_q),
		.res    (ores)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and memory strobes
	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		pt_we     = 1'b0;
		pt_raddr  = '0;
		stk_we    = 1'b0;
		stk_waddr = '0;
		stk_wdata = '0;
		stk_raddr = '0;
		o_start   = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				s_tready = 1'b1;
				if (in_acc) begin
					pt_we = !full;
					if (s_tlast) begin
						state_d = (cnt_nxt < CW'(3)) ? ST_E_STK : ST_INIT_A;
					end
				end
			end
			ST_INIT_A: begin
				stk_we    = 1'b1;
				stk_waddr = '0;
				stk_wdata = first_idx;
				pt_raddr  = first_idx;
				state_d   = ST_INIT_B;
			end
			ST_INIT_B: begin
				stk_we    = 1'b1;
				stk_waddr = IW'(1);
				stk_wdata = second_idx;
				pt_raddr  = second_idx;
				state_d   = ST_INIT_C;
			end
			ST_INIT_C: state_d = ST_FETCH;
			ST_FETCH: begin
				pt_raddr = c_q;
				state_d  = ST_FETCH_W;
			end
			ST_FETCH_W: state_d = ST_TEST;
			ST_TEST: begin
				if (dep_q >= CW'(2)) begin
					o_start = 1'b1;
					state_d = ST_WAIT;
				end else begin
					state_d = ST_PUSH;
				end
			end
			ST_WAIT: begin
				if (ores.done) begin
					state_d = (ores.pop && dep_q >= CW'(3)) ? ST_RLD_S : ST_PUSH;
				end
			end
			ST_RLD_S: begin
				stk_raddr = dep_m2[IW-1:0];
				state_d   = ST_RLD_P;
			end
			ST_RLD_P: begin
				pt_raddr = stk_rd;
				state_d  = ST_RLD_W;
			end
			ST_RLD_W: state_d = ST_TEST;
			ST_PUSH: begin
				stk_we    = !stk_full;
				stk_waddr = dep_q[IW-1:0];
				stk_wdata = c_q;
				if (left_q == CW'(1)) begin
					state_d = sel_q ? ST_E_STK : ST_INIT_A;
				end else begin
					state_d = ST_FETCH;
				end
			end
			ST_E_STK: begin
				if (small_q) begin
					pt_raddr = e_idx_q;
					state_d  = ST_E_LD;
				end else begin
					stk_raddr = e_idx_q;
					state_d   = ST_E_PT;
				end
			end
			ST_E_PT: begin
				pt_raddr = stk_rd;
				state_d  = ST_E_LD;
			end
			ST_E_LD: state_d = ST_E_WAIT;
			ST_E_WAIT: begin
				if (m_tready) begin
					state_d = m_last_q ? ST_LOAD : ST_E_STK;
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

	// counters, depths and indices
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			drop_q    <= 1'b0;
			n_q       <= '0;
			sel_q     <= 1'b0;
			small_q   <= 1'b0;
			left_q    <= '0;
			dep_q     <= '0;
			fdep_q    <= '0;
			c_q       <= '0;
			e_idx_q   <= '0;
			m_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						cnt_q  <= cnt_nxt;
						drop_q <= drop_q | full;
						if (s_tlast) begin
							n_q     <= cnt_nxt;
							sel_q   <= 1'b0;
							small_q <= (cnt_nxt < CW'(3));
							left_q  <= cnt_nxt;
							e_idx_q <= '0;
						end
					end
				end
				ST_INIT_C: begin
					dep_q  <= CW'(2);
					c_q    <= sel_q ? n_m3[IW-1:0] : IW'(2);
					left_q <= n_m2;
				end
				ST_WAIT: begin
					if (ores.done && ores.pop) dep_q <= dep_q - CW'(1);
				end
				ST_PUSH: begin
					dep_q <= dep_push;
					if (left_q == CW'(1)) begin
						if (!sel_q) begin
							fdep_q <= dep_push;
							sel_q  <= 1'b1;
						end else begin
							e_idx_q <= IW'(dep_push - CW'(2));
							left_q  <= emit_tot;
						end
					end else begin
						left_q <= left_q - CW'(1);
						c_q    <= sel_q ? c_q - IW'(1) : c_q + IW'(1);
					end
				end
				ST_E_LD: m_valid_q <= 1'b1;
				ST_E_WAIT: begin
					if (m_tready) begin
						m_valid_q <= 1'b0;
						left_q    <= left_q - CW'(1);
						if (m_last_q) begin
							cnt_q  <= '0;
							drop_q <= 1'b0;
						end else if (small_q) begin
							e_idx_q <= e_idx_q + IW'(1);
						end else if (e_idx_q == '0) begin
							sel_q   <= 1'b0;
							e_idx_q <= fdep_m2[IW-1:0];
						end else begin
							e_idx_q <= e_idx_q - IW'(1);
						end
					end
				end
				default: ;
			endcase
		end
	end

	// coordinate registers and output beat
	always_ff @(posedge clk) begin
		case (state_q)
			ST_INIT_B: begin
				ax_q <= rd_x;
				ay_q <= rd_y;
			end
			ST_INIT_C: begin
				bx_q <= rd_x;
				by_q <= rd_y;
			end
			ST_FETCH_W: begin
				cx_q <= rd_x;
				cy_q <= rd_y;
			end
			ST_WAIT: begin
				if (ores.done && ores.pop) begin
					bx_q <= ax_q;
					by_q <= ay_q;
				end
			end
			ST_RLD_W: begin
				ax_q <= rd_x;
				ay_q <= rd_y;
			end
			ST_PUSH: begin
				if (!stk_full) begin
					ax_q <= bx_q;
					ay_q <= by_q;
					bx_q <= cx_q;
					by_q <= cy_q;
				end
			end
			ST_E_LD: begin
				hx_q     <= rd_x;
				hy_q     <= rd_y;
				m_last_q <= (left_q == CW'(1));
				m_ovf_q  <= drop_q;
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = DW'({hy_q, hx_q});
	assign m_tlast  = m_last_q;
	assign m_tuser  = m_ovf_q;

	// checks
	`MCCH_CHECK(a_no_overlap, !(s_tready && m_tvalid), "point taken while a vertex waits")
	`MCCH_CHECK(a_done_in_wait, !ores.done || (state_q == ST_WAIT), "stray orientation result")
	`MCCH_CHECK(a_depth_bound, dep_q <= CW'(MAX_POINTS), "stack depth past capacity")
	`MCCH_CHECK(a_count_bound, cnt_q <= CW'(MAX_POINTS), "point count past capacity")
	`MCCH_CHECK_NEXT(a_hull_done, m_tvalid && m_tready && m_tlast, s_tready && (cnt_q == '0), "no fresh set after hull")

endmodule
